// ===== rtl/rcfd_pkg.sv =====
// shared types and constants of the remote command failsafe decoder
`default_nettype none
package rcfd_pkg;

   localparam int COUNTER_WIDTH_DEFAULT = 16;
   localparam int PERIOD_WIDTH          = 16;
   localparam int CSR_INDEX_WIDTH       = 1;

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd7812;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INSTRUCTOR_PERIOD = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STUDENT_PERIOD    = 1'b1;

   // item kinds
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_PACKET = 1'b1;

   localparam logic [5:0] PACKET_SIZE     = 6'd4;
   localparam logic [2:0] INSTRUCTOR_PIPE = 3'd0;
   localparam logic [2:0] STUDENT_PIPE    = 3'd1;

   // flag byte layout
   localparam int FLAG_ESTOP     = 0;
   localparam int FLAG_LIFT_LSB  = 1;
   localparam int FLAG_LIFT_MSB  = 2;
   localparam int FLAG_STU_LSB   = 3;
   localparam int FLAG_STU_MSB   = 6;

   typedef struct packed {
      logic              func;
      logic        [2:0] pipe;
      logic        [5:0] payload_size;
      logic        [7:0] flag_byte;
      logic signed [7:0] direction_byte;
      logic signed [7:0] speed_byte;
   } req_item_type;

   typedef struct packed {
      logic              estop_latched;
      logic              lift_up;
      logic              lift_down;
      logic signed [7:0] instructor_speed;
      logic signed [7:0] instructor_direction;
      logic        [3:0] student_buttons;
      logic signed [7:0] student_speed;
      logic signed [7:0] student_direction;
      logic              instructor_link_lost;
      logic        [1:0] timeouts_fired;
   } rsp_item_type;

   // stored packet: flags, direction, speed
   typedef struct packed {
      logic [7:0] speed;
      logic [7:0] direction;
      logic [7:0] flags;
   } packet_type;

   typedef struct packed {
      logic       lift_up;
      logic       lift_down;
      logic [7:0] speed;
      logic [7:0] direction;
   } instructor_type;

   typedef struct packed {
      logic [3:0] buttons;
      logic [7:0] speed;
      logic [7:0] direction;
   } student_type;

   // watchdog control from the top level
   typedef struct packed {
      logic tick;
      logic restart;
   } wd_ctrl_type;

endpackage
`default_nettype wire

// ===== rtl/rcfd_req_if.sv =====
// request channel interface
`default_nettype none
interface rcfd_req_if;
   import rcfd_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rcfd_rsp_if.sv =====
// response channel interface
`default_nettype none
interface rcfd_rsp_if;
   import rcfd_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rcfd_watchdog.sv =====
// link watchdog counter with wrap and fire
`default_nettype none
module rcfd_watchdog #(
   parameter int COUNTER_WIDTH = rcfd_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rcfd_pkg::wd_ctrl_type             ctrl,
   input  wire logic [rcfd_pkg::PERIOD_WIDTH-1:0] period,
   output logic                                   fire
);
   import rcfd_pkg::*;

   localparam int CMP_WIDTH = (COUNTER_WIDTH > PERIOD_WIDTH) ? COUNTER_WIDTH : PERIOD_WIDTH;

   logic [COUNTER_WIDTH-1:0] count_ff;
   logic [COUNTER_WIDTH-1:0] count_in;
   logic [CMP_WIDTH-1:0]     count_ext;
   logic [CMP_WIDTH-1:0]     period_ext;

   assign count_ext  = CMP_WIDTH'(count_ff);
   assign period_ext = CMP_WIDTH'(period);

   // fires on a tick when the count has reached the period
   assign fire = ctrl.tick && (count_ext >= period_ext);

   always_comb begin
      count_in = count_ff;
      if (ctrl.restart || fire) begin
         count_in = '0;
      end else if (ctrl.tick) begin
         count_in = count_ff + {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/remote_command_failsafe_decoder.sv =====
// top level of the remote command failsafe decoder
`default_nettype none
// Takes one item per clock: a timer tick or a received packet. Each accepted
// item updates the watchdogs, the stored packet and the command fields in the
// same cycle and loads one result into the output register, which shows the
// command state after that item; the result appears in the cycle after
// acceptance. The output register frees as it is taken, so the block accepts
// an item every cycle while the result side keeps up, and at most one result
// waits. Only 4-byte packets are stored; pipe 0 packets feed the instructor
// watchdog and fields, pipe 1 packets the student ones. An instructor timeout
// sets link-lost, which blocks all decoding until the next good pipe 0 packet.
// Estop is sticky until reset. The two timeout periods are to be written on the csr
// port while idle, which the block does not enforce; both reset to 7812 ticks.
module remote_command_failsafe_decoder #(
   parameter int COUNTER_WIDTH = rcfd_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   rcfd_req_if.sink                                  req_ch,
   rcfd_rsp_if.source                                rsp_ch,
   input  wire logic                                 csr_we,
   input  wire logic [rcfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rcfd_pkg::PERIOD_WIDTH-1:0]    csr_wdata
);
   import rcfd_pkg::*;

   // timeout periods
   logic [PERIOD_WIDTH-1:0] ins_period_ff;
   logic [PERIOD_WIDTH-1:0] stu_period_ff;

   // decoder state
   logic           link_lost_ff,  link_lost_in;
   logic           estop_ff,      estop_in;
   packet_type     packet_ff,     packet_in;
   logic [2:0]     pipe_ff,       pipe_in;
   instructor_type ins_ff,        ins_in;
   student_type    stu_ff,        stu_in;

   // output register
   logic           rsp_valid_ff;
   rsp_item_type   rsp_data_ff,   rsp_data_in;

   logic           accept;
   logic           is_packet;
   logic           is_tick;
   logic           size_ok;
   logic           ins_fire;
   logic           stu_fire;
   wd_ctrl_type    ins_ctrl;
   wd_ctrl_type    stu_ctrl;

   // an item enters whenever the output register is empty or being emptied
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign is_packet = accept && (req_ch.data.func == FUNC_PACKET);
   assign is_tick   = accept && (req_ch.data.func == FUNC_TICK);
   assign size_ok   = req_ch.data.payload_size == PACKET_SIZE;

   assign ins_ctrl.tick    = is_tick;
   assign ins_ctrl.restart = is_packet && size_ok && (req_ch.data.pipe == INSTRUCTOR_PIPE);
   assign stu_ctrl.tick    = is_tick;
   assign stu_ctrl.restart = is_packet && size_ok && (req_ch.data.pipe == STUDENT_PIPE);

   rcfd_watchdog #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_ins_wd (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ins_ctrl),
      .period (ins_period_ff),
      .fire   (ins_fire)
   );

   rcfd_watchdog #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_stu_wd (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (stu_ctrl),
      .period (stu_period_ff),
      .fire   (stu_fire)
   );

   // next state for one item
   always_comb begin
      link_lost_in = link_lost_ff;
      estop_in     = estop_ff;
      packet_in    = packet_ff;
      pipe_in      = pipe_ff;
      ins_in       = ins_ff;
      stu_in       = stu_ff;

      if (is_packet) begin
         // store a packet of the right size
         if (size_ok) begin
            packet_in.flags     = req_ch.data.flag_byte;
            packet_in.direction = req_ch.data.direction_byte;
            packet_in.speed     = req_ch.data.speed_byte;
            pipe_in             = req_ch.data.pipe;
            if (req_ch.data.pipe == INSTRUCTOR_PIPE) begin
               link_lost_in = 1'b0;
            end
         end
         // decode the last stored packet unless the link is lost
         if (!link_lost_in) begin
            if (packet_in.flags[FLAG_ESTOP]) begin
               estop_in = 1'b1;
            end
            if (pipe_in == INSTRUCTOR_PIPE) begin
               {ins_in.lift_down, ins_in.lift_up} =
                  packet_in.flags[FLAG_LIFT_MSB:FLAG_LIFT_LSB];
               ins_in.speed     = packet_in.speed;
               ins_in.direction = packet_in.direction;
            end
            if (pipe_in == STUDENT_PIPE) begin
               stu_in.buttons   = packet_in.flags[FLAG_STU_MSB:FLAG_STU_LSB];
               stu_in.speed     = packet_in.speed;
               stu_in.direction = packet_in.direction;
            end
         end
      end else begin
         // instructor timeout acts first
         if (ins_fire) begin
            link_lost_in = 1'b1;
            packet_in    = '0;
            pipe_in      = INSTRUCTOR_PIPE;
            ins_in       = '0;
            stu_in       = '0;
         end
         if (stu_fire) begin
            packet_in = '0;
            pipe_in   = STUDENT_PIPE;
            stu_in    = '0;
         end
      end
   end

   // result shows the state after the item
   always_comb begin
      rsp_data_in.estop_latched        = estop_in;
      rsp_data_in.lift_up              = ins_in.lift_up;
      rsp_data_in.lift_down            = ins_in.lift_down;
      rsp_data_in.instructor_speed     = ins_in.speed;
      rsp_data_in.instructor_direction = ins_in.direction;
      rsp_data_in.student_buttons      = stu_in.buttons;
      rsp_data_in.student_speed        = stu_in.speed;
      rsp_data_in.student_direction    = stu_in.direction;
      rsp_data_in.instructor_link_lost = link_lost_in;
      rsp_data_in.timeouts_fired       = {1'b0, ins_fire} + {1'b0, stu_fire};
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ins_period_ff <= PERIOD_RESET;
         stu_period_ff <= PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INSTRUCTOR_PERIOD: ins_period_ff <= csr_wdata;
            CSR_STUDENT_PERIOD:    stu_period_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         link_lost_ff <= 1'b0;
         estop_ff     <= 1'b0;
         packet_ff    <= '0;
         pipe_ff      <= '0;
         ins_ff       <= '0;
         stu_ff       <= '0;
      end else if (accept) begin
         link_lost_ff <= link_lost_in;
         estop_ff     <= estop_in;
         packet_ff    <= packet_in;
         pipe_ff      <= pipe_in;
         ins_ff       <= ins_in;
         stu_ff       <= stu_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/rcfd_checker.sv =====
// port checker for the remote command failsafe decoder, with its bind
`default_nettype none
module rcfd_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire rcfd_pkg::req_item_type req_data,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire rcfd_pkg::rsp_item_type rsp_data
);
   import rcfd_pkg::*;

   // a packet item never fires a watchdog
   a_packet_no_fire: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.func == FUNC_PACKET))
      |=> (rsp_valid && (rsp_data.timeouts_fired == 2'd0)))
      else $error("packet item reported a timeout");

   // while the link is lost no command field is live
   a_link_lost_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.instructor_link_lost)
      |-> (!rsp_data.lift_up && !rsp_data.lift_down &&
           (rsp_data.instructor_speed == 8'sd0) &&
           (rsp_data.instructor_direction == 8'sd0) &&
           (rsp_data.student_buttons == 4'd0) &&
           (rsp_data.student_speed == 8'sd0) &&
           (rsp_data.student_direction == 8'sd0)))
      else $error("command fields live while link lost");

   // estop stays once shown
   a_estop_sticky: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid) && $past(rsp_data.estop_latched) && rsp_valid)
      |-> rsp_data.estop_latched)
      else $error("estop released");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind remote_command_failsafe_decoder rcfd_checker u_rcfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_data  (req_ch.data),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
`default_nettype wire

// ===== test/testbench.sv =====
// testbench of the remote command failsafe decoder: directed and random items, self-checking
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rcfd_pkg::*;

   // which side of the handshake idles in the current stretch
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam int ITEMS_PER_PHASE = 200;
   localparam int PHASE_COUNT     = 8;
   localparam int HOLD_CYCLES     = 40;
   localparam int SETTLE_CYCLES   = 4;

   // tracks the decoder state and checks every result against it
   class failsafe_scoreboard;
      rsp_item_type                expected_commands[$];
      int unsigned                 errors;
      logic [PERIOD_WIDTH-1:0]     ins_period;
      logic [PERIOD_WIDTH-1:0]     stu_period;
      logic [COUNTER_WIDTH_DEFAULT-1:0] ins_count;
      logic [COUNTER_WIDTH_DEFAULT-1:0] stu_count;
      logic                        link_lost;
      logic                        estop;
      packet_type                  stored_pkt;
      logic [2:0]                  last_pipe;
      instructor_type              ins_cmd;
      student_type                 stu_cmd;

      function new();
         errors      = 0;
         ins_period  = PERIOD_RESET;
         stu_period  = PERIOD_RESET;
         ins_count   = '0;
         stu_count   = '0;
         link_lost   = 1'b0;
         estop       = 1'b0;
         stored_pkt  = '0;
         last_pipe   = INSTRUCTOR_PIPE;
         ins_cmd     = '0;
         stu_cmd     = '0;
      endfunction

      function void set_periods(logic [PERIOD_WIDTH-1:0] ins, logic [PERIOD_WIDTH-1:0] stu);
         ins_period = ins;
         stu_period = stu;
      endfunction

      function int pending();
         return expected_commands.size();
      endfunction

      // turn the last stored packet into command fields
      function void decode_last();
         if (stored_pkt.flags[FLAG_ESTOP]) estop = 1'b1;
         if (last_pipe == INSTRUCTOR_PIPE) begin
            ins_cmd.lift_up   = stored_pkt.flags[FLAG_LIFT_LSB];
            ins_cmd.lift_down = stored_pkt.flags[FLAG_LIFT_MSB];
            ins_cmd.speed     = stored_pkt.speed;
            ins_cmd.direction = stored_pkt.direction;
         end
         if (last_pipe == STUDENT_PIPE) begin
            stu_cmd.buttons   = stored_pkt.flags[FLAG_STU_MSB:FLAG_STU_LSB];
            stu_cmd.speed     = stored_pkt.speed;
            stu_cmd.direction = stored_pkt.direction;
         end
      endfunction

      // command state after one tick or packet
      function rsp_item_type step_decoder(req_item_type it);
         rsp_item_type r;
         logic [1:0]   fired;
         logic         ins_fire;
         logic         stu_fire;
         fired    = '0;
         ins_fire = 1'b0;
         stu_fire = 1'b0;
         if (it.func == FUNC_PACKET) begin
            if (it.payload_size == PACKET_SIZE) begin
               stored_pkt.flags     = it.flag_byte;
               stored_pkt.direction = it.direction_byte;
               stored_pkt.speed     = it.speed_byte;
               last_pipe            = it.pipe;
               if (it.pipe == INSTRUCTOR_PIPE) begin
                  ins_count = '0;
                  link_lost = 1'b0;
               end
               if (it.pipe == STUDENT_PIPE) stu_count = '0;
            end
            if (!link_lost) decode_last();
         end else begin
            if (ins_count >= ins_period) begin
               ins_count = '0;
               ins_fire  = 1'b1;
            end else begin
               ins_count = ins_count + 1'b1;
            end
            if (stu_count >= stu_period) begin
               stu_count = '0;
               stu_fire  = 1'b1;
            end else begin
               stu_count = stu_count + 1'b1;
            end
            // instructor acts first, so a double fire leaves the student pipe stored
            if (ins_fire) begin
               link_lost   = 1'b1;
               stored_pkt  = '0;
               last_pipe   = INSTRUCTOR_PIPE;
               ins_cmd     = '0;
               stu_cmd     = '0;
               fired       = fired + 2'd1;
            end
            if (stu_fire) begin
               stored_pkt  = '0;
               last_pipe   = STUDENT_PIPE;
               stu_cmd     = '0;
               fired       = fired + 2'd1;
            end
         end
         r.estop_latched        = estop;
         r.lift_up              = ins_cmd.lift_up;
         r.lift_down            = ins_cmd.lift_down;
         r.instructor_speed     = ins_cmd.speed;
         r.instructor_direction = ins_cmd.direction;
         r.student_buttons      = stu_cmd.buttons;
         r.student_speed        = stu_cmd.speed;
         r.student_direction    = stu_cmd.direction;
         r.instructor_link_lost = link_lost;
         r.timeouts_fired       = fired;
         return r;
      endfunction

      function void note_item(req_item_type it);
         expected_commands.push_back(step_decoder(it));
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_commands.size() == 0) begin
            $error("result arrived with no item waiting: 'h%0h", got);
            errors++;
            return;
         end
         want = expected_commands.pop_front();
         check_field("estop_latched", want.estop_latched, got.estop_latched);
         check_field("lift_up", want.lift_up, got.lift_up);
         check_field("lift_down", want.lift_down, got.lift_down);
         check_field("instructor_speed", want.instructor_speed, got.instructor_speed);
         check_field("instructor_direction", want.instructor_direction,
                     got.instructor_direction);
         check_field("student_buttons", want.student_buttons, got.student_buttons);
         check_field("student_speed", want.student_speed, got.student_speed);
         check_field("student_direction", want.student_direction, got.student_direction);
         check_field("instructor_link_lost", want.instructor_link_lost,
                     got.instructor_link_lost);
         check_field("timeouts_fired", want.timeouts_fired, got.timeouts_fired);
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [PERIOD_WIDTH-1:0]    csr_wdata;

   rcfd_req_if req_ch();
   rcfd_rsp_if rsp_ch();

   failsafe_scoreboard sb = new();

   // idling pattern of the current phase, and a request for a long receiver hold-off
   idle_mode_type idle_mode = IDLE_NONE;
   bit            hold_request = 1'b0;

   remote_command_failsafe_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // sender gap: 67 in a hundred alone, 38 when both sides idle
   function automatic bit sender_waits();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 67;
         IDLE_BOTH:   return $urandom_range(0, 99) < 38;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(0, 99) < 67;
         IDLE_BOTH:     return $urandom_range(0, 99) < 38;
         default:       return 1'b0;
      endcase
   endfunction

   // build a packet item
   function automatic req_item_type make_packet(logic [2:0] pipe, logic [5:0] size,
                                                logic [7:0] flags, logic [7:0] dir,
                                                logic [7:0] spd);
      req_item_type it;
      it.func           = FUNC_PACKET;
      it.pipe           = pipe;
      it.payload_size   = size;
      it.flag_byte      = flags;
      it.direction_byte = dir;
      it.speed_byte     = spd;
      return it;
   endfunction

   // tick with random filler in the unused fields
   function automatic req_item_type make_tick();
      req_item_type it;
      it      = req_item_type'($urandom());
      it.func = FUNC_TICK;
      return it;
   endfunction

   // mostly well-formed packets on the two real pipes, with some noise
   function automatic req_item_type random_item(bit allow_estop);
      req_item_type it;
      int           roll;
      if ($urandom_range(0, 99) < 50) return make_tick();
      it = make_packet(3'd0, PACKET_SIZE, 8'($urandom()), 8'($urandom()), 8'($urandom()));
      roll = $urandom_range(0, 99);
      if (roll < 45)      it.pipe = INSTRUCTOR_PIPE;
      else if (roll < 85) it.pipe = STUDENT_PIPE;
      else                it.pipe = 3'($urandom_range(2, 7));
      roll = $urandom_range(0, 99);
      if (roll >= 95)      it.payload_size = 6'($urandom_range(33, 63));
      else if (roll >= 85) it.payload_size = 6'($urandom_range(0, 32));
      // estop is sticky, so keep it clear for the first half of the random phases
      if (!allow_estop) it.flag_byte[FLAG_ESTOP] = 1'b0;
      return it;
   endfunction

   // offer one item, with random gaps before it, until it is taken
   task automatic send_item(input req_item_type it);
      while (sender_waits()) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= it;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop offering and wait until every expected result has come back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // write both watchdog periods on back-to-back cycles
   task automatic set_periods(input logic [PERIOD_WIDTH-1:0] ins,
                              input logic [PERIOD_WIDTH-1:0] stu);
      csr_we    <= 1'b1;
      csr_index <= CSR_INSTRUCTOR_PERIOD;
      csr_wdata <= ins;
      @(posedge clock);
      csr_index <= CSR_STUDENT_PERIOD;
      csr_wdata <= stu;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_periods(ins, stu);
   endtask

   // every handshake is sampled at the edge, before any driver updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
         if (req_ch.valid && req_ch.ready) sb.note_item(req_ch.data);
      end
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !receiver_stalls();
         end
      end
   end

   // stimulus
   initial begin
      logic [PERIOD_WIDTH-1:0] ins_plan[PHASE_COUNT];
      logic [PERIOD_WIDTH-1:0] stu_plan[PHASE_COUNT];
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      csr_we       <= 1'b0;
      csr_index    <= CSR_INSTRUCTOR_PERIOD;
      csr_wdata    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: decoding at the reset periods, no watchdog can fire yet
      send_item(make_tick());
      send_item(make_packet(INSTRUCTOR_PIPE, PACKET_SIZE, 8'h06, 8'h80, 8'h7F));
      send_item(make_packet(STUDENT_PIPE, PACKET_SIZE, 8'h78, 8'h7F, 8'h80));
      send_item(make_packet(INSTRUCTOR_PIPE, PACKET_SIZE, 8'hFE, 8'h7F, 8'h80));
      // wrong sizes are dropped but the stored packet is decoded again
      send_item(make_packet(STUDENT_PIPE, 6'd5, 8'h00, 8'h00, 8'h00));
      send_item(make_packet(INSTRUCTOR_PIPE, 6'd0, 8'h00, 8'h00, 8'h00));
      // a packet on another pipe is stored but drives no fields
      send_item(make_packet(3'd7, PACKET_SIZE, 8'h7E, 8'h01, 8'hFF));
      send_item(make_packet(STUDENT_PIPE, 6'd32, 8'hFF, 8'h12, 8'h34));
      send_item(make_packet(3'd2, 6'd63, 8'hFF, 8'h80, 8'h80));
      send_item(make_tick());
      wait_idle();

      // period zero: both watchdogs fire on every tick, instructor first
      set_periods('0, '0);
      send_item(make_tick());
      // link lost blocks decoding, even of an estop bit
      send_item(make_packet(STUDENT_PIPE, PACKET_SIZE, 8'h79, 8'h11, 8'h22));
      send_item(make_packet(INSTRUCTOR_PIPE, PACKET_SIZE, 8'h06, 8'h05, 8'hFB));
      send_item(make_packet(STUDENT_PIPE, PACKET_SIZE, 8'h28, 8'h40, 8'h80));
      wait_idle();

      // short periods, raised from zero
      set_periods(16'd2, 16'd1);
      send_item(make_tick());
      send_item(make_tick());
      send_item(make_tick());
      send_item(make_packet(INSTRUCTOR_PIPE, PACKET_SIZE, 8'h00, 8'h55, 8'h2A));
      send_item(make_packet(3'd4, PACKET_SIZE, 8'h01, 8'h00, 8'h00));
      send_item(make_tick());
      wait_idle();

      // random phases: reset periods, the extremes, period zero, then short random ones
      ins_plan = '{PERIOD_RESET, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      stu_plan = '{PERIOD_RESET, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      for (int p = 4; p < PHASE_COUNT; p++) begin
         ins_plan[p] = PERIOD_WIDTH'($urandom_range(1, 40));
         stu_plan[p] = PERIOD_WIDTH'($urandom_range(1, 40));
      end
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_periods(ins_plan[p], stu_plan[p]);
         idle_mode = idle_mode_type'(p % 4);
         // hold the result side while items keep coming so the input stalls
         if (p == 0 || p == 4) hold_request = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_item(p >= PHASE_COUNT / 2));
         // sender pause until everything has come back
         wait_idle();
      end

      idle_mode = IDLE_NONE;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
